@@ sv/assert_macros.svh @@
// Assertion macros shared by the range distinct-count engine.
// Expects clk and arst_n to be visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked only while the block is out of reset.
`define ASSERT_CLKD(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define ASSERT_ANY(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLKD(label, prop, msg)
`define ASSERT_ANY(label, prop, msg)
`endif
`endif

@@ sv/swdc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the range distinct-count engine.
// No dependencies; every other file but assert_macros.svh imports this package.
package swdc_pkg;

	localparam int POS_W = 17;
	localparam int VAL_W = 16;
	localparam int TOTAL_W = 17;

	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] item_value;
		logic [POS_W-1:0] range_left;
		logic [POS_W-1:0] range_right;
	} req_word_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_MOVE,
		ST_LD_OUT,
		ST_LD_WR,
		ST_LD_IN,
		ST_STEP_V,
		ST_STEP_H,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		JOB_QUERY,
		JOB_LOAD_OUT,
		JOB_LOAD_IN
	} job_t;

	typedef enum logic [2:0] {
		MV_NONE,
		MV_GROW_HIGH,
		MV_GROW_LOW,
		MV_SHRINK_HIGH,
		MV_SHRINK_LOW
	} move_t;

	typedef struct packed {
		logic clr_en;
		logic accept;
		logic win_init;
		logic store_wr;
		logic issue_move;
		logic issue_load;
		logic load_in;
		logic hist_rd;
		logic hist_upd;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic  clr_last;
		logic  is_query;
		logic  item_err;
		logic  in_window;
		logic  win_empty;
		move_t move;
		logic  out_free;
	} ctrl_sts_t;

endpackage

@@ sv/swdc_req_if.sv @@
`timescale 1ns / 1ps
// Request channel: valid/ready handshake carrying one load or query word.
// Depends on swdc_pkg for field widths.
interface swdc_req_if import swdc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             cmd;
	logic [POS_W-1:0] position;
	logic [VAL_W-1:0] item_value;
	logic [POS_W-1:0] range_left;
	logic [POS_W-1:0] range_right;

	modport source (
		output valid, cmd, position, item_value, range_left, range_right,
		input  ready
	);
	modport sink (
		input  valid, cmd, position, item_value, range_left, range_right,
		output ready
	);
endinterface

@@ sv/swdc_rsp_if.sv @@
`timescale 1ns / 1ps
// Response channel: valid/ready handshake carrying one result word.
// Depends on swdc_pkg for field widths.
interface swdc_rsp_if import swdc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [TOTAL_W-1:0] distinct_total;
	logic               range_error;

	modport source (
		output valid, distinct_total, range_error,
		input  ready
	);
	modport sink (
		input  valid, distinct_total, range_error,
		output ready
	);
endinterface

@@ sv/swdc_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine of the range distinct-count engine.
// Depends on swdc_pkg and assert_macros.svh; drives the datapath by command struct.
`include "assert_macros.svh"
module swdc_ctrl import swdc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);

	state_t state_q, state_d;
	job_t   job_q, job_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			job_q   <= JOB_QUERY;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		job_d    = job_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (sts.item_err) begin
					state_d = ST_EMIT;
				end else if (sts.is_query) begin
					cmd.win_init = sts.win_empty;
					job_d        = JOB_QUERY;
					state_d      = ST_MOVE;
				end else if (sts.in_window) begin
					state_d = ST_LD_OUT;
				end else begin
					cmd.store_wr = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_MOVE: begin
				if (sts.move == MV_NONE) begin
					state_d = ST_EMIT;
				end else begin
					cmd.issue_move = 1'b1;
					state_d        = ST_STEP_V;
				end
			end
			ST_LD_OUT: begin
				cmd.issue_load = 1'b1;
				job_d          = JOB_LOAD_OUT;
				state_d        = ST_STEP_V;
			end
			ST_LD_WR: begin
				cmd.store_wr = 1'b1;
				state_d      = ST_LD_IN;
			end
			ST_LD_IN: begin
				cmd.issue_load = 1'b1;
				cmd.load_in    = 1'b1;
				job_d          = JOB_LOAD_IN;
				state_d        = ST_STEP_V;
			end
			ST_STEP_V: begin
				cmd.hist_rd = 1'b1;
				state_d     = ST_STEP_H;
			end
			ST_STEP_H: begin
				cmd.hist_upd = 1'b1;
				unique case (job_q)
					JOB_QUERY:    state_d = ST_MOVE;
					JOB_LOAD_OUT: state_d = ST_LD_WR;
					JOB_LOAD_IN:  state_d = ST_IDLE;
					default:      state_d = ST_IDLE;
				endcase
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`ASSERT_CLKD(a_upd_follows_rd, cmd.hist_upd |-> $past(cmd.hist_rd), "histogram update without read")
	`ASSERT_CLKD(a_emit_has_room, cmd.emit |-> sts.out_free, "result word issued into a full output register")

endmodule

@@ sv/swdc_dpath.sv @@
`timescale 1ns / 1ps
// Datapath of the range distinct-count engine: value store, occurrence histogram,
// window registers and the output register. Depends on swdc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module swdc_dpath import swdc_pkg::*; #(
	parameter int ARRAY_DEPTH = 65536,
	parameter int VALUE_RANGE = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  req_word_t          req_word,
	input  logic               rsp_ready,
	input  ctrl_cmd_t          cmd,
	output ctrl_sts_t          sts,
	output logic               rsp_valid,
	output logic [TOTAL_W-1:0] rsp_total,
	output logic               rsp_error
);

	localparam int AW = $clog2(ARRAY_DEPTH);
	localparam int VAW = $clog2(VALUE_RANGE);
	localparam int CW = $clog2(ARRAY_DEPTH + 1);
	localparam logic [31:0] DEPTH_W = 32'(ARRAY_DEPTH);
	localparam logic [31:0] RANGE_W = 32'(VALUE_RANGE);
	localparam logic [VAW-1:0] CLR_LAST = VAW'(VALUE_RANGE - 1);

	req_word_t        item_q;
	logic             item_err_q;
	logic             in_win_q;
	logic [POS_W-1:0] win_low_q;
	logic [POS_W-1:0] win_high_q;
	logic             win_empty_q;
	logic [CW-1:0]    distinct_q;
	logic             dir_in_q;
	logic [VAW-1:0]   clr_q;
	logic [VAL_W-1:0] store_rdata_q;
	logic [CW-1:0]    hist_rdata_q;
	logic             rsp_valid_q;
	logic [TOTAL_W-1:0] rsp_total_q;
	logic             rsp_err_q;

	logic [VAL_W-1:0] store_mem [ARRAY_DEPTH];
	logic [CW-1:0]    hist_mem [VALUE_RANGE];

	logic             load_err;
	logic             query_err;
	logic             acc_err;
	logic             acc_in_win;
	move_t            move;
	logic [POS_W-1:0] step_pos;
	logic [31:0]      step_addr32;
	logic [31:0]      wr_addr32;
	logic [31:0]      val32;
	logic [31:0]      dist32;
	logic [AW-1:0]    step_addr;
	logic [AW-1:0]    wr_addr;
	logic [VAW-1:0]   hist_addr;
	logic             hist_we;
	logic [VAW-1:0]   hist_waddr;
	logic [CW-1:0]    hist_wdata;
	logic [POS_W:0]   high_plus1;

	// Checks on the word at the input; they are registered at acceptance.
	assign load_err = (req_word.position == '0) || (32'(req_word.position) > DEPTH_W)
		|| (32'(req_word.item_value) >= RANGE_W);
	assign query_err = (req_word.range_left == '0)
		|| (req_word.range_left > req_word.range_right)
		|| (32'(req_word.range_right) > DEPTH_W);
	assign acc_err = (req_word.cmd == CMD_QUERY) ? query_err : load_err;
	assign acc_in_win = !win_empty_q && (req_word.position >= win_low_q)
		&& (req_word.position <= win_high_q);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q     <= req_word;
			item_err_q <= acc_err;
			in_win_q   <= acc_in_win;
		end
	end

	// The window grows at both ends before it shrinks, so no count drops below zero.
	always_comb begin
		if (win_high_q < item_q.range_right) begin
			move = MV_GROW_HIGH;
		end else if (win_low_q > item_q.range_left) begin
			move = MV_GROW_LOW;
		end else if (win_high_q > item_q.range_right) begin
			move = MV_SHRINK_HIGH;
		end else if (win_low_q < item_q.range_left) begin
			move = MV_SHRINK_LOW;
		end else begin
			move = MV_NONE;
		end
	end

	always_comb begin
		if (cmd.issue_load) begin
			step_pos = item_q.position;
		end else begin
			unique case (move)
				MV_GROW_HIGH:   step_pos = win_high_q + POS_W'(1);
				MV_GROW_LOW:    step_pos = win_low_q - POS_W'(1);
				MV_SHRINK_HIGH: step_pos = win_high_q;
				MV_SHRINK_LOW:  step_pos = win_low_q;
				MV_NONE:        step_pos = win_low_q;
				default:        step_pos = win_low_q;
			endcase
		end
	end

	assign step_addr32 = 32'(step_pos) - 32'd1;
	assign step_addr   = step_addr32[AW-1:0];
	assign wr_addr32   = 32'(item_q.position) - 32'd1;
	assign wr_addr     = wr_addr32[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_low_q   <= POS_W'(1);
			win_high_q  <= '0;
			win_empty_q <= 1'b1;
		end else if (cmd.win_init) begin
			win_low_q   <= item_q.range_left;
			win_high_q  <= item_q.range_left - POS_W'(1);
			win_empty_q <= 1'b0;
		end else if (cmd.issue_move) begin
			unique case (move)
				MV_GROW_HIGH:   win_high_q <= win_high_q + POS_W'(1);
				MV_GROW_LOW:    win_low_q  <= win_low_q - POS_W'(1);
				MV_SHRINK_HIGH: win_high_q <= win_high_q - POS_W'(1);
				MV_SHRINK_LOW:  win_low_q  <= win_low_q + POS_W'(1);
				MV_NONE:        win_low_q  <= win_low_q;
				default:        win_low_q  <= win_low_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue_move) begin
			dir_in_q <= (move == MV_GROW_HIGH) || (move == MV_GROW_LOW);
		end else if (cmd.issue_load) begin
			dir_in_q <= cmd.load_in;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_wr) begin
			store_mem[wr_addr] <= item_q.item_value;
		end
		if (cmd.issue_move || cmd.issue_load) begin
			store_rdata_q <= store_mem[step_addr];
		end
	end

	assign val32     = 32'(store_rdata_q);
	assign hist_addr = val32[VAW-1:0];

	// A count already at zero is left alone when a value is counted out.
	always_comb begin
		hist_we    = cmd.clr_en || (cmd.hist_upd && (dir_in_q || (hist_rdata_q != '0)));
		hist_waddr = cmd.clr_en ? clr_q : hist_addr;
		if (cmd.clr_en) begin
			hist_wdata = '0;
		end else if (dir_in_q) begin
			hist_wdata = hist_rdata_q + CW'(1);
		end else begin
			hist_wdata = hist_rdata_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= hist_wdata;
		end
		if (cmd.hist_rd) begin
			hist_rdata_q <= hist_mem[hist_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			distinct_q <= '0;
		end else if (cmd.hist_upd) begin
			if (dir_in_q && (hist_rdata_q == '0)) begin
				distinct_q <= distinct_q + CW'(1);
			end else if (!dir_in_q && (hist_rdata_q == CW'(1)) && (distinct_q != '0)) begin
				distinct_q <= distinct_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_en) begin
			clr_q <= clr_q + VAW'(1);
		end
	end

	assign dist32 = 32'(distinct_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_err_q   <= item_err_q;
			rsp_total_q <= item_err_q ? '0 : dist32[TOTAL_W-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_total = rsp_total_q;
	assign rsp_error = rsp_err_q;

	assign sts.clr_last  = (clr_q == CLR_LAST);
	assign sts.is_query  = (item_q.cmd == CMD_QUERY);
	assign sts.item_err  = item_err_q;
	assign sts.in_window = in_win_q;
	assign sts.win_empty = win_empty_q;
	assign sts.move      = move;
	assign sts.out_free  = !rsp_valid_q || rsp_ready;

	assign high_plus1 = (POS_W + 1)'(win_high_q) + (POS_W + 1)'(1);

	`ASSERT_CLKD(a_window_ordered, !win_empty_q |-> ((POS_W + 1)'(win_low_q) <= high_plus1), "window low end passed high end")
	`ASSERT_ANY(a_error_total_zero, (rsp_valid_q && rsp_err_q) |-> (rsp_total_q == '0), "rejected word carries a nonzero total")

endmodule

@@ sv/sliding_window_distinct_count.sv @@
`timescale 1ns / 1ps
// Top level of the range distinct-count engine: controller, datapath and channel glue.
// Depends on swdc_pkg, swdc_req_if, swdc_rsp_if, swdc_ctrl and swdc_dpath.
//
// Loads write values into a position array; queries return the number of distinct
// values in positions range_left..range_right, answered in arrival order by sliding
// one window over the array. After reset the histogram memory is swept to zero, one
// entry per cycle, over all VALUE_RANGE entries; no word is accepted during that sweep.
// One word is worked on at a time. Every step of a window end is a value-store read,
// a histogram read and a histogram write-back, each memory having one registered read
// port. A load inside the window counts the old value out, writes the new one and
// counts it in. Rejected words and answered queries each give one result word; good
// loads give none. A finished result waits in an output register while the next word
// is accepted.
module sliding_window_distinct_count import swdc_pkg::*; #(
	parameter int ARRAY_DEPTH = 65536,
	parameter int VALUE_RANGE = 65536
) (
	input logic        clk,
	input logic        arst_n,
	swdc_req_if.sink   req,
	swdc_rsp_if.source rsp
);

	req_word_t          req_word;
	ctrl_cmd_t          cmd;
	ctrl_sts_t          sts;
	logic               in_ready;
	logic               rsp_valid;
	logic [TOTAL_W-1:0] rsp_total;
	logic               rsp_error;

	assign req_word.cmd         = req.cmd;
	assign req_word.position    = req.position;
	assign req_word.item_value  = req.item_value;
	assign req_word.range_left  = req.range_left;
	assign req_word.range_right = req.range_right;
	assign req.ready            = in_ready;

	assign rsp.valid          = rsp_valid;
	assign rsp.distinct_total = rsp_total;
	assign rsp.range_error    = rsp_error;

	swdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	swdc_dpath #(
		.ARRAY_DEPTH (ARRAY_DEPTH),
		.VALUE_RANGE (VALUE_RANGE)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_word  (req_word),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_total (rsp_total),
		.rsp_error (rsp_error)
	);

endmodule

@@ tb/sliding_window_distinct_count_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the range distinct-count engine: a directed table, then random
// loads and queries, each answer checked against its typed row or a window/histogram predictor.
// Depends on swdc_pkg, swdc_req_if, swdc_rsp_if and sliding_window_distinct_count.
module sliding_window_distinct_count_tb;
	import swdc_pkg::*;

	localparam int ARRAY_DEPTH = 65536;
	localparam int VALUE_RANGE = 65536;
	localparam logic CMD_LOAD = 1'b0;
	localparam int RANDOM_WORDS = 300;
	localparam int FILL_TOP = 192;
	localparam int CYCLE_LIMIT = 6_000_000;
	localparam int TAIL_CYCLES = 40;
	localparam int HOLD_AT_RESULT = 120;
	localparam int LONG_HOLD = 600;
	localparam int PAUSE_AT_WORD = 250;

	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic               err;
	} answer_t;

	typedef enum logic {ROW_WORD, ROW_FILL} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		req_word_t word;
		logic      typed;
		answer_t   answer;
	} row_t;

	localparam answer_t REJECTED = '{17'd0, 1'b1};
	localparam answer_t ONE_VALUE = '{17'd1, 1'b0};
	localparam answer_t NO_ANSWER = '0;

	localparam int NROWS = 23;
	localparam row_t DIRECTED [NROWS] = '{
		'{ROW_WORD, '{CMD_QUERY, 17'd0, 16'd0, 17'd0, 17'd5}, 1'b1, REJECTED},
		'{ROW_WORD, '{CMD_QUERY, 17'd0, 16'd0, 17'd7, 17'd6}, 1'b1, REJECTED},
		'{ROW_WORD, '{CMD_QUERY, 17'd0, 16'd0, 17'd1, 17'd65537}, 1'b1, REJECTED},
		'{ROW_WORD, '{CMD_QUERY, 17'd0, 16'd0, 17'd65536, 17'd1}, 1'b1, REJECTED},
		'{ROW_WORD, '{CMD_QUERY, 17'd0, 16'd0, 17'd131071, 17'd131071}, 1'b1, REJECTED},
		'{ROW_WORD, '{CMD_LOAD, 17'd0, 16'd5, 17'd0, 17'd0}, 1'b1, REJECTED},
		'{ROW_WORD, '{CMD_LOAD, 17'd65537, 16'd0, 17'd0, 17'd0}, 1'b1, REJECTED},
		'{ROW_WORD, '{CMD_LOAD, 17'd131071, 16'hFFFF, 17'd0, 17'd0}, 1'b1, REJECTED},
		'{ROW_WORD, '{CMD_LOAD, 17'd65536, 16'hFFFF, 17'd0, 17'd0}, 1'b0, NO_ANSWER},
		'{ROW_WORD, '{CMD_LOAD, 17'd65536, 16'd0, 17'd0, 17'd0}, 1'b0, NO_ANSWER},
		'{ROW_FILL, '0, 1'b0, NO_ANSWER},
		// First query on the empty window sets it up from scratch.
		'{ROW_WORD, '{CMD_QUERY, 17'd0, 16'd0, 17'd1, 17'd192}, 1'b0, NO_ANSWER},
		'{ROW_WORD, '{CMD_QUERY, 17'd0, 16'd0, 17'd1, 17'd1}, 1'b1, ONE_VALUE},
		'{ROW_WORD, '{CMD_LOAD, 17'd1, 16'hFFFF, 17'd0, 17'd0}, 1'b0, NO_ANSWER},
		'{ROW_WORD, '{CMD_QUERY, 17'd0, 16'd0, 17'd1, 17'd1}, 1'b1, ONE_VALUE},
		'{ROW_WORD, '{CMD_LOAD, 17'd2, 16'hFFFF, 17'd0, 17'd0}, 1'b0, NO_ANSWER},
		'{ROW_WORD, '{CMD_QUERY, 17'd0, 16'd0, 17'd1, 17'd2}, 1'b1, ONE_VALUE},
		'{ROW_WORD, '{CMD_QUERY, 17'd0, 16'd0, 17'd3, 17'd3}, 1'b1, ONE_VALUE},
		'{ROW_WORD, '{CMD_QUERY, 17'd0, 16'd0, 17'd2, 17'd5}, 1'b0, NO_ANSWER},
		'{ROW_WORD, '{CMD_LOAD, 17'd4, 16'h5A5A, 17'd0, 17'd0}, 1'b0, NO_ANSWER},
		'{ROW_WORD, '{CMD_QUERY, 17'd0, 16'd0, 17'd1, 17'd8}, 1'b0, NO_ANSWER},
		'{ROW_WORD, '{CMD_QUERY, 17'd0, 16'd0, 17'd9, 17'd8}, 1'b1, REJECTED},
		'{ROW_WORD, '{CMD_QUERY, 17'd0, 16'd0, 17'd1, 17'd8}, 1'b0, NO_ANSWER}
	};

	logic clk;
	logic arst_n;

	swdc_req_if req_ch ();
	swdc_rsp_if rsp_ch ();

	sliding_window_distinct_count #(
		.ARRAY_DEPTH(ARRAY_DEPTH),
		.VALUE_RANGE(VALUE_RANGE)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Predictor state: array contents, per-value counts inside the window, window bounds.
	logic [VAL_W-1:0] stored_values [ARRAY_DEPTH];
	int unsigned      value_hist [VALUE_RANGE];
	int unsigned      win_lo = 1;
	int unsigned      win_hi = 0;
	bit               win_empty = 1'b1;
	int unsigned      live_distinct = 0;

	answer_t     answers_due [$];
	int unsigned bad_results = 0;

	function automatic void hist_add(input int unsigned pos);
		logic [VAL_W-1:0] v;
		v = stored_values[pos - 1];
		value_hist[v]++;
		if (value_hist[v] == 1)
			live_distinct++;
	endfunction

	function automatic void hist_remove(input int unsigned pos);
		logic [VAL_W-1:0] v;
		v = stored_values[pos - 1];
		if (value_hist[v] != 0) begin
			value_hist[v]--;
			if (value_hist[v] == 0 && live_distinct > 0)
				live_distinct--;
		end
	endfunction

	// Applies one word to the predictor; returns 1 when the word produces a result word.
	function automatic bit predict_answer(input req_word_t w, output answer_t a);
		a = '0;
		if (w.cmd == CMD_LOAD) begin
			if (w.position == 0 || w.position > ARRAY_DEPTH || w.item_value >= VALUE_RANGE) begin
				a.err = 1'b1;
				return 1'b1;
			end
			if (!win_empty && w.position >= win_lo && w.position <= win_hi) begin
				hist_remove(32'(w.position));
				stored_values[w.position - 1] = w.item_value;
				hist_add(32'(w.position));
			end else begin
				stored_values[w.position - 1] = w.item_value;
			end
			return 1'b0;
		end
		if (w.range_left == 0 || w.range_left > w.range_right || w.range_right > ARRAY_DEPTH) begin
			a.err = 1'b1;
			return 1'b1;
		end
		if (win_empty) begin
			win_lo = 32'(w.range_left);
			win_hi = 32'(w.range_left) - 1;
			win_empty = 1'b0;
		end
		// Grow both ends before shrinking so that no count drops below zero.
		while (win_hi < w.range_right) begin
			win_hi++;
			hist_add(win_hi);
		end
		while (win_lo > w.range_left) begin
			win_lo--;
			hist_add(win_lo);
		end
		while (win_hi > w.range_right) begin
			hist_remove(win_hi);
			win_hi--;
		end
		while (win_lo < w.range_left) begin
			hist_remove(win_lo);
			win_lo++;
		end
		a.total = live_distinct[TOTAL_W-1:0];
		return 1'b1;
	endfunction

	// Offers one word after the given gap and waits for it to be taken.
	task automatic send_word(input req_word_t w, input int unsigned gap, input bit typed,
			input answer_t typed_answer);
		answer_t predicted;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= w.cmd;
		req_ch.position <= w.position;
		req_ch.item_value <= w.item_value;
		req_ch.range_left <= w.range_left;
		req_ch.range_right <= w.range_right;
		do @(posedge clk); while (!req_ch.ready);
		if (predict_answer(w, predicted))
			answers_due.push_back(typed ? typed_answer : predicted);
	endtask

	initial begin : word_source
		req_word_t   w;
		int unsigned p;
		int unsigned pick;
		int unsigned gap;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= CMD_LOAD;
		req_ch.position <= '0;
		req_ch.item_value <= '0;
		req_ch.range_left <= '0;
		req_ch.range_right <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_FILL) begin
				// Write the low positions back to back; every later window stays among them
				// and so never reaches an unwritten entry.
				for (p = 1; p <= FILL_TOP; p++) begin
					w = '0;
					w.cmd = CMD_LOAD;
					w.position = POS_W'(p);
					w.item_value = ($urandom_range(0, 15) == 0) ? 16'($urandom())
						: 16'($urandom_range(0, 255));
					send_word(w, 0, 1'b0, NO_ANSWER);
				end
			end else begin
				send_word(DIRECTED[i].word, $urandom_range(0, 19), DIRECTED[i].typed,
					DIRECTED[i].answer);
			end
		end

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			w.cmd = 1'($urandom());
			w.position = 17'($urandom());
			w.item_value = 16'($urandom());
			w.range_left = 17'($urandom());
			w.range_right = 17'($urandom());
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				w.cmd = CMD_LOAD;
				w.position = 17'($urandom_range(1, 160));
				if ($urandom_range(0, 3) != 0)
					w.item_value = 16'($urandom_range(0, 31));
			end else if (pick < 42) begin
				w.cmd = CMD_LOAD;
				w.position = 17'($urandom_range(1, ARRAY_DEPTH));
			end else if (pick < 47) begin
				w.cmd = CMD_LOAD;
				w.position = ($urandom_range(0, 1) == 0) ? 17'd0
					: 17'($urandom_range(ARRAY_DEPTH + 1, 131071));
			end else if (pick < 90) begin
				w.cmd = CMD_QUERY;
				if ($urandom_range(0, 49) == 0) begin
					w.range_left = 17'($urandom_range(1, 16));
					w.range_right = 17'($urandom_range(FILL_TOP / 2, FILL_TOP));
				end else begin
					w.range_left = 17'($urandom_range(1, 128));
					w.range_right = 17'(w.range_left + $urandom_range(0, 40));
				end
			end else begin
				w.cmd = CMD_QUERY;
				case ($urandom_range(0, 2))
					0: w.range_left = '0;
					1: begin
						w.range_left = 17'($urandom_range(2, 131071));
						w.range_right = 17'($urandom_range(1, w.range_left - 1));
					end
					default: begin
						w.range_right = 17'($urandom_range(ARRAY_DEPTH + 1, 131071));
						w.range_left = 17'($urandom_range(1, w.range_right));
					end
				endcase
			end

			if (n == PAUSE_AT_WORD) begin
				// Let the engine drain completely before going on.
				req_ch.valid <= 1'b0;
				do @(posedge clk); while (answers_due.size() != 0);
			end
			gap = (n >= 60 && n < 120) ? 0 : $urandom_range(0, 19);
			send_word(w, gap, 1'b0, NO_ANSWER);
		end

		req_ch.valid <= 1'b0;
		do @(posedge clk); while (answers_due.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (bad_results == 0 && answers_due.size() == 0)
			$display("sliding_window_distinct_count_tb passed");
		else
			$display("sliding_window_distinct_count_tb failed");
		$finish;
	end

	initial begin : result_sink
		answer_t     want;
		int unsigned seen;
		int unsigned hold;
		seen = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			// One long hold lets the engine back up into the request channel.
			if (seen == HOLD_AT_RESULT)
				hold = LONG_HOLD;
			else if (seen >= 180 && seen < 220)
				hold = 0;
			else
				hold = $urandom_range(0, 19);
			if (hold > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			seen++;
			if (answers_due.size() == 0) begin
				if (bad_results < 10)
					$display("unexpected result word: total %0d error %0b",
						rsp_ch.distinct_total, rsp_ch.range_error);
				bad_results++;
			end else begin
				want = answers_due.pop_front();
				if (rsp_ch.distinct_total !== want.total || rsp_ch.range_error !== want.err) begin
					if (bad_results < 10)
						$display("result %0d: expected total %0d error %0b, got total %0d error %0b",
							seen, want.total, want.err, rsp_ch.distinct_total, rsp_ch.range_error);
					bad_results++;
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
			@(posedge clk);
		$display("sliding_window_distinct_count_tb failed");
		$finish;
	end

endmodule
